// ----- sv/gzhp_pkg.sv -----
// ============================================================================
// gzhp_pkg: shared codes for the gzip member header parser
// Status and byte class codes, magic bytes, flag bit positions and the
// field widths of the item streams.
// ============================================================================
package gzhp_pkg;

    // Per-byte status codes.
    localparam logic [1:0] ST_TAKEN    = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
    localparam logic [1:0] ST_OUTSIDE  = 2'd3;

    // Per-byte class codes.
    localparam logic [3:0] CLS_ID      = 4'd0;
    localparam logic [3:0] CLS_METHOD  = 4'd1;
    localparam logic [3:0] CLS_FLAGS   = 4'd2;
    localparam logic [3:0] CLS_MTIME   = 4'd3;
    localparam logic [3:0] CLS_XFL     = 4'd4;
    localparam logic [3:0] CLS_OS      = 4'd5;
    localparam logic [3:0] CLS_XLEN    = 4'd6;
    localparam logic [3:0] CLS_EXTRA   = 4'd7;
    localparam logic [3:0] CLS_NAME    = 4'd8;
    localparam logic [3:0] CLS_COMMENT = 4'd9;
    localparam logic [3:0] CLS_HCRC    = 4'd10;
    localparam logic [3:0] CLS_PAYLOAD = 4'd11;
    localparam logic [3:0] CLS_ERROR   = 4'd12;

    // Magic bytes of a member header.
    localparam logic [7:0] MAGIC_ID1 = 8'h1f;
    localparam logic [7:0] MAGIC_ID2 = 8'h8b;

    // Bit positions of the optional sections in FLG.
    localparam int unsigned FLG_FHCRC    = 1;
    localparam int unsigned FLG_FEXTRA   = 2;
    localparam int unsigned FLG_FNAME    = 3;
    localparam int unsigned FLG_FCOMMENT = 4;

    // Stream widths.
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned IN_USER_W  = 1;
    localparam int unsigned OUT_DATA_W = 64;
    localparam int unsigned OUT_USER_W = 6;

endpackage

// ----- sv/gzip_header_parser.sv -----
// ============================================================================
// gzip_header_parser: gzip member header parser
// Walks a gzip member header one byte per item, checks the magic bytes,
// captures the fixed fields and classifies every byte of the optional
// sections.
// ============================================================================
// The parser takes one byte per cycle and answers every byte with exactly one
// result item, in the cycle after it is accepted; a new byte is taken in every
// cycle in which the result register is empty or is being read, so the
// sustained rate is one byte per clock. The rate is set by the phase state
// machine, whose update for a byte is combinational. A byte with
// start_req set opens a new header at any time. The captured header fields are
// shown on every result as they stand after that byte.
module gzip_header_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input item stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [gzhp_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // data_byte[7:0]
    input  logic [gzhp_pkg::IN_USER_W-1:0]      s_axis_tuser,   // start_req[0]
    // Result item stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // method[7:0], header_flags[15:8], mod_time[47:16], extra_flags[55:48],
    // os_code[63:56]
    output logic [gzhp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status[1:0], byte_class[5:2]
    output logic [gzhp_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ID2     = 4'd1,
        PH_FIXED   = 4'd2,
        PH_XLEN    = 4'd3,
        PH_EXTRA   = 4'd4,
        PH_NAME    = 4'd5,
        PH_COMMENT = 4'd6,
        PH_HCRC    = 4'd7,
        PH_ERROR   = 4'd8
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  index_reg, index_next;
    logic        id_ok_reg, id_ok_next;
    logic [15:0] extra_reg, extra_next;
    logic [7:0]  method_reg, method_next;
    logic [7:0]  flags_reg, flags_next;
    logic [31:0] mtime_reg, mtime_next;
    logic [7:0]  xfl_reg, xfl_next;
    logic [7:0]  os_reg, os_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [3:0]  class_reg, class_next;

    logic        accept;
    logic [7:0]  data_byte;
    logic        start_req;
    logic [15:0] extra_dec;
    phase_t      after_phase;

    // First optional section after the given one whose flag is set.
    function automatic phase_t section_after(input phase_t done, input logic [7:0] flg);
        phase_t res;
        begin
            if (done < PH_XLEN && flg[gzhp_pkg::FLG_FEXTRA])
                res = PH_XLEN;
            else if (done < PH_NAME && flg[gzhp_pkg::FLG_FNAME])
                res = PH_NAME;
            else if (done < PH_COMMENT && flg[gzhp_pkg::FLG_FCOMMENT])
                res = PH_COMMENT;
            else if (done < PH_HCRC && flg[gzhp_pkg::FLG_FHCRC])
                res = PH_HCRC;
            else
                res = PH_IDLE;
            return res;
        end
    endfunction

    // Handshake: the result register parts the two sides.
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign data_byte     = s_axis_tdata[7:0];
    assign start_req     = s_axis_tuser[0];
    assign extra_dec     = extra_reg - 16'd1;

    // Phase update for one byte.
    always_comb
    begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        id_ok_next  = id_ok_reg;
        extra_next  = extra_reg;
        method_next = method_reg;
        flags_next  = flags_reg;
        mtime_next  = mtime_reg;
        xfl_next    = xfl_reg;
        os_next     = os_reg;
        status_next = gzhp_pkg::ST_TAKEN;
        class_next  = gzhp_pkg::CLS_PAYLOAD;
        after_phase = PH_IDLE;

        if (start_req)
        begin
            method_next = '0;
            flags_next  = '0;
            mtime_next  = '0;
            xfl_next    = '0;
            os_next     = '0;
            extra_next  = '0;
            index_next  = '0;
            id_ok_next  = (data_byte == gzhp_pkg::MAGIC_ID1);
            phase_next  = PH_ID2;
            class_next  = gzhp_pkg::CLS_ID;
        end
        else
        begin
            case (phase_reg)
                PH_ID2:
                begin
                    class_next = gzhp_pkg::CLS_ID;
                    if (id_ok_reg && data_byte == gzhp_pkg::MAGIC_ID2)
                    begin
                        phase_next = PH_FIXED;
                        index_next = '0;
                    end
                    else
                    begin
                        status_next = gzhp_pkg::ST_BAD_MAGIC;
                        phase_next  = PH_ERROR;
                    end
                end
                PH_FIXED:
                begin
                    case (index_reg)
                        3'd0:
                        begin
                            class_next  = gzhp_pkg::CLS_METHOD;
                            method_next = data_byte;
                        end
                        3'd1:
                        begin
                            class_next = gzhp_pkg::CLS_FLAGS;
                            flags_next = data_byte;
                        end
                        3'd2, 3'd3, 3'd4, 3'd5:
                        begin
                            class_next = gzhp_pkg::CLS_MTIME;
                            mtime_next[8 * (index_reg[1:0] ^ 2'd2) +: 8] =
                                mtime_reg[8 * (index_reg[1:0] ^ 2'd2) +: 8] | data_byte;
                        end
                        3'd6:
                        begin
                            class_next = gzhp_pkg::CLS_XFL;
                            xfl_next   = data_byte;
                        end
                        default:
                        begin
                            class_next = gzhp_pkg::CLS_OS;
                            os_next    = data_byte;
                        end
                    endcase
                    if (index_reg == 3'd7)
                    begin
                        after_phase = section_after(PH_FIXED, flags_reg);
                        phase_next  = after_phase;
                        index_next  = '0;
                        if (after_phase == PH_IDLE)
                            status_next = gzhp_pkg::ST_COMPLETE;
                    end
                    else
                    begin
                        index_next = index_reg + 3'd1;
                    end
                end
                PH_XLEN:
                begin
                    class_next = gzhp_pkg::CLS_XLEN;
                    if (!index_reg[0])
                    begin
                        extra_next = {8'd0, data_byte};
                        index_next = 3'd1;
                    end
                    else
                    begin
                        extra_next = {data_byte, extra_reg[7:0]};
                        index_next = '0;
                        if ({data_byte, extra_reg[7:0]} == 16'd0)
                        begin
                            after_phase = section_after(PH_EXTRA, flags_reg);
                            phase_next  = after_phase;
                            if (after_phase == PH_IDLE)
                                status_next = gzhp_pkg::ST_COMPLETE;
                        end
                        else
                        begin
                            phase_next = PH_EXTRA;
                        end
                    end
                end
                PH_EXTRA:
                begin
                    class_next = gzhp_pkg::CLS_EXTRA;
                    extra_next = extra_dec;
                    if (extra_dec == 16'd0)
                    begin
                        after_phase = section_after(PH_EXTRA, flags_reg);
                        phase_next  = after_phase;
                        index_next  = '0;
                        if (after_phase == PH_IDLE)
                            status_next = gzhp_pkg::ST_COMPLETE;
                    end
                end
                PH_NAME, PH_COMMENT:
                begin
                    class_next = (phase_reg == PH_NAME) ? gzhp_pkg::CLS_NAME
                                                        : gzhp_pkg::CLS_COMMENT;
                    if (data_byte == 8'd0)
                    begin
                        after_phase = section_after(phase_reg, flags_reg);
                        phase_next  = after_phase;
                        index_next  = '0;
                        if (after_phase == PH_IDLE)
                            status_next = gzhp_pkg::ST_COMPLETE;
                    end
                end
                PH_HCRC:
                begin
                    class_next = gzhp_pkg::CLS_HCRC;
                    if (!index_reg[0])
                    begin
                        index_next = 3'd1;
                    end
                    else
                    begin
                        phase_next  = PH_IDLE;
                        index_next  = '0;
                        status_next = gzhp_pkg::ST_COMPLETE;
                    end
                end
                PH_ERROR:
                begin
                    class_next  = gzhp_pkg::CLS_ERROR;
                    status_next = gzhp_pkg::ST_OUTSIDE;
                end
                default:
                begin
                    phase_next  = PH_IDLE;
                    class_next  = gzhp_pkg::CLS_PAYLOAD;
                    status_next = gzhp_pkg::ST_OUTSIDE;
                end
            endcase
        end
    end

    // The result register fills on an accepted byte and empties when read.
    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            index_reg     <= '0;
            id_ok_reg     <= 1'b0;
            extra_reg     <= '0;
            method_reg    <= '0;
            flags_reg     <= '0;
            mtime_reg     <= '0;
            xfl_reg       <= '0;
            os_reg        <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= gzhp_pkg::ST_OUTSIDE;
            class_reg     <= gzhp_pkg::CLS_PAYLOAD;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg  <= phase_next;
                index_reg  <= index_next;
                id_ok_reg  <= id_ok_next;
                extra_reg  <= extra_next;
                method_reg <= method_next;
                flags_reg  <= flags_next;
                mtime_reg  <= mtime_next;
                xfl_reg    <= xfl_next;
                os_reg     <= os_next;
                status_reg <= status_next;
                class_reg  <= class_next;
            end
        end
    end

    // The captured fields change only on an accepted byte, which needs the
    // result register free, so they drive the result payload directly.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {os_reg, xfl_reg, mtime_reg, flags_reg, method_reg};
    assign m_axis_tuser  = {class_reg, status_reg};

    // A byte with the start flag always yields an ID result next cycle.
    a_start_id: assert property (@(posedge clk) disable iff (!rst_n)
        accept && start_req |=> m_axis_tvalid && class_reg == gzhp_pkg::CLS_ID
            && status_reg == gzhp_pkg::ST_TAKEN)
        else $error("start byte not reported as header ID");

    // Bad magic is only ever reported on an ID byte and leads to the error phase.
    a_bad_magic: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && status_reg == gzhp_pkg::ST_BAD_MAGIC |->
            class_reg == gzhp_pkg::CLS_ID && phase_reg == PH_ERROR)
        else $error("bad magic reported outside the ID check");

    // The extra section is never entered with nothing left to skip.
    a_extra_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_EXTRA |-> extra_reg != 16'd0)
        else $error("extra section active with zero count");

    // Two-byte sections use only the low index bit.
    a_pair_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_XLEN || phase_reg == PH_HCRC |-> index_reg[2:1] == 2'd0)
        else $error("pair index out of range");

    // A completed header leaves the parser outside any header.
    a_complete_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) && status_reg == gzhp_pkg::ST_COMPLETE |->
            phase_reg == PH_IDLE)
        else $error("header complete but parser still inside a section");

endmodule

// ----- sim/gzip_header_parser_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// gzip_header_parser_checker: result checker for the gzip header parser
// Watches both item streams of the parser, keeps its own copy of the header
// walk, works out the result of every accepted byte and compares each result
// item with the oldest pending prediction, field by field.
// ============================================================================
module gzip_header_parser_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [gzhp_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // data_byte[7:0]
    input  logic [gzhp_pkg::IN_USER_W-1:0]      s_axis_tuser,   // start_req[0]
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // method[7:0], header_flags[15:8], mod_time[47:16], extra_flags[55:48],
    // os_code[63:56]
    input  logic [gzhp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status[1:0], byte_class[5:2]
    input  logic [gzhp_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    output int                                  fail_count,
    output int                                  pending
);

    // Sections of the header walk, in the order they appear in a member.
    typedef enum logic [3:0] {
        SEC_IDLE,
        SEC_ID2,
        SEC_FIXED,
        SEC_XLEN,
        SEC_EXTRA,
        SEC_NAME,
        SEC_COMMENT,
        SEC_HCRC,
        SEC_BAD
    } hdr_section_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  cls;
        logic [7:0]  cm;
        logic [7:0]  flg;
        logic [31:0] mtime;
        logic [7:0]  xfl;
        logic [7:0]  os;
    } hdr_result_t;

    // Predicted parser state.
    hdr_section_t section_q;
    logic [2:0]   byte_idx_q;
    logic         id1_ok_q;
    logic [15:0]  extra_left_q;
    logic [7:0]   cm_q;
    logic [7:0]   flg_q;
    logic [31:0]  mtime_q;
    logic [7:0]   xfl_q;
    logic [7:0]   os_q;

    hdr_result_t  due_results[$];
    hdr_result_t  oldest;
    int           mismatches = 0;
    int           due_count = 0;

    assign fail_count = mismatches;
    assign pending    = due_count;

    // Leaves a finished section for the next one whose flag is set; the byte
    // completes the header when none is left.
    function automatic logic [1:0] close_section(input hdr_section_t done);
        hdr_section_t nxt;
        nxt = SEC_IDLE;
        if (done < SEC_XLEN && flg_q[gzhp_pkg::FLG_FEXTRA])
            nxt = SEC_XLEN;
        else if (done < SEC_NAME && flg_q[gzhp_pkg::FLG_FNAME])
            nxt = SEC_NAME;
        else if (done < SEC_COMMENT && flg_q[gzhp_pkg::FLG_FCOMMENT])
            nxt = SEC_COMMENT;
        else if (done < SEC_HCRC && flg_q[gzhp_pkg::FLG_FHCRC])
            nxt = SEC_HCRC;
        section_q  = nxt;
        byte_idx_q = '0;
        return (nxt == SEC_IDLE) ? gzhp_pkg::ST_COMPLETE : gzhp_pkg::ST_TAKEN;
    endfunction

    // Advances the header walk by one byte and returns the result it causes.
    function automatic hdr_result_t walk_header_byte(input logic [7:0] b, input logic first);
        hdr_result_t r;
        r.status = gzhp_pkg::ST_TAKEN;
        r.cls    = gzhp_pkg::CLS_PAYLOAD;
        if (first)
        begin
            cm_q         = '0;
            flg_q        = '0;
            mtime_q      = '0;
            xfl_q        = '0;
            os_q         = '0;
            extra_left_q = '0;
            byte_idx_q   = '0;
            id1_ok_q     = (b == gzhp_pkg::MAGIC_ID1);
            section_q    = SEC_ID2;
            r.cls        = gzhp_pkg::CLS_ID;
        end
        else
        begin
            case (section_q)
                SEC_ID2:
                begin
                    r.cls = gzhp_pkg::CLS_ID;
                    if (id1_ok_q && b == gzhp_pkg::MAGIC_ID2)
                    begin
                        section_q  = SEC_FIXED;
                        byte_idx_q = '0;
                    end
                    else
                    begin
                        r.status  = gzhp_pkg::ST_BAD_MAGIC;
                        section_q = SEC_BAD;
                    end
                end
                SEC_FIXED:
                begin
                    case (byte_idx_q)
                        3'd0:
                        begin
                            r.cls = gzhp_pkg::CLS_METHOD;
                            cm_q  = b;
                        end
                        3'd1:
                        begin
                            r.cls = gzhp_pkg::CLS_FLAGS;
                            flg_q = b;
                        end
                        3'd6:
                        begin
                            r.cls = gzhp_pkg::CLS_XFL;
                            xfl_q = b;
                        end
                        3'd7:
                        begin
                            r.cls = gzhp_pkg::CLS_OS;
                            os_q  = b;
                        end
                        default:
                        begin
                            r.cls = gzhp_pkg::CLS_MTIME;
                            mtime_q[8*(byte_idx_q-2) +: 8] = b;
                        end
                    endcase
                    if (byte_idx_q == 3'd7)
                        r.status = close_section(SEC_FIXED);
                    else
                        byte_idx_q = byte_idx_q + 3'd1;
                end
                SEC_XLEN:
                begin
                    r.cls = gzhp_pkg::CLS_XLEN;
                    if (!byte_idx_q[0])
                    begin
                        extra_left_q = {8'h00, b};
                        byte_idx_q   = 3'd1;
                    end
                    else
                    begin
                        extra_left_q = {b, extra_left_q[7:0]};
                        byte_idx_q   = '0;
                        // An empty extra field ends the section on this byte.
                        if (extra_left_q == '0)
                            r.status = close_section(SEC_EXTRA);
                        else
                            section_q = SEC_EXTRA;
                    end
                end
                SEC_EXTRA:
                begin
                    r.cls        = gzhp_pkg::CLS_EXTRA;
                    extra_left_q = extra_left_q - 16'd1;
                    if (extra_left_q == '0)
                        r.status = close_section(SEC_EXTRA);
                end
                SEC_NAME:
                begin
                    r.cls = gzhp_pkg::CLS_NAME;
                    if (b == 8'h00)
                        r.status = close_section(SEC_NAME);
                end
                SEC_COMMENT:
                begin
                    r.cls = gzhp_pkg::CLS_COMMENT;
                    if (b == 8'h00)
                        r.status = close_section(SEC_COMMENT);
                end
                SEC_HCRC:
                begin
                    r.cls = gzhp_pkg::CLS_HCRC;
                    if (!byte_idx_q[0])
                        byte_idx_q = 3'd1;
                    else
                        r.status = close_section(SEC_HCRC);
                end
                SEC_BAD:
                begin
                    r.cls    = gzhp_pkg::CLS_ERROR;
                    r.status = gzhp_pkg::ST_OUTSIDE;
                end
                default:
                begin
                    section_q = SEC_IDLE;
                    r.status  = gzhp_pkg::ST_OUTSIDE;
                end
            endcase
        end
        r.cm    = cm_q;
        r.flg   = flg_q;
        r.mtime = mtime_q;
        r.xfl   = xfl_q;
        r.os    = os_q;
        return r;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endtask

    // Compare result items first, then predict the byte accepted at this edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_q    = SEC_IDLE;
            byte_idx_q   = '0;
            id1_ok_q     = 1'b0;
            extra_left_q = '0;
            cm_q         = '0;
            flg_q        = '0;
            mtime_q      = '0;
            xfl_q        = '0;
            os_q         = '0;
            due_results.delete();
            due_count    = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result item with nothing pending, tuser 0x%0h tdata 0x%0h",
                             $time, m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    oldest = due_results.pop_front();
                    check_field("status",       oldest.status, m_axis_tuser[1:0]);
                    check_field("byte_class",   oldest.cls,    m_axis_tuser[5:2]);
                    check_field("method",       oldest.cm,     m_axis_tdata[7:0]);
                    check_field("header_flags", oldest.flg,    m_axis_tdata[15:8]);
                    check_field("mod_time",     oldest.mtime,  m_axis_tdata[47:16]);
                    check_field("extra_flags",  oldest.xfl,    m_axis_tdata[55:48]);
                    check_field("os_code",      oldest.os,     m_axis_tdata[63:56]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                due_results.push_back(walk_header_byte(s_axis_tdata, s_axis_tuser[0]));
            due_count = due_results.size();
        end
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb: testbench for the gzip member header parser
// Feeds directed corner cases and then random gzip member headers, broken
// headers and noise through the parser, both streams stalling at random in
// the first two thirds; the checker predicts and compares every result item.
// ============================================================================
module tb;

    localparam int N_ITEMS     = 1250;
    localparam int CYCLE_LIMIT = 400000;

    logic                               clk;
    logic                               rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [gzhp_pkg::IN_DATA_W-1:0]     s_axis_tdata;   // data_byte[7:0]
    logic [gzhp_pkg::IN_USER_W-1:0]     s_axis_tuser;   // start_req[0]
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    // method[7:0], header_flags[15:8], mod_time[47:16], extra_flags[55:48],
    // os_code[63:56]
    logic [gzhp_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    // status[1:0], byte_class[5:2]
    logic [gzhp_pkg::OUT_USER_W-1:0]    m_axis_tuser;

    int fail_count;
    int pending;
    int items_sent = 0;
    int cycles = 0;
    int src_idle_pct = 30;
    int dst_idle_pct = 88;

    // Bytes of the next stretch of stimulus: {start_req, data_byte}.
    logic [8:0] byte_plan[$];

    gzip_header_parser dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    gzip_header_parser_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Result side: stalls at the rate of the current idling phase.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Offers one item after a random gap and returns at the edge that takes it.
    task automatic send_item(input logic [8:0] item);
        logic hit;
        if (items_sent < N_ITEMS / 3)
        begin
            src_idle_pct = 30;
            dst_idle_pct = 88;
        end
        else if (items_sent < 2 * N_ITEMS / 3)
        begin
            src_idle_pct = 88;
            dst_idle_pct = 30;
        end
        else
        begin
            src_idle_pct = 0;
            dst_idle_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item[7:0];
        s_axis_tuser  <= item[8];
        // Ready is stable between edges, so it is sampled mid-cycle.
        do
        begin
            @(negedge clk);
            hit = s_axis_tready;
            @(posedge clk);
        end
        while (!hit);
        items_sent++;
    endtask

    task automatic play_plan();
        while (byte_plan.size() > 0)
            send_item(byte_plan.pop_front());
    endtask

    // A well-formed member header with random content, now and then cut short,
    // followed by a few payload bytes.
    task automatic plan_member();
        logic [7:0]  flg;
        logic [15:0] xlen;
        int          n;
        int          cut;
        flg = 8'($urandom_range(255));
        byte_plan.push_back({1'b1, gzhp_pkg::MAGIC_ID1});
        byte_plan.push_back({1'b0, gzhp_pkg::MAGIC_ID2});
        byte_plan.push_back({1'b0, ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h08});
        byte_plan.push_back({1'b0, flg});
        repeat (6)
            byte_plan.push_back({1'b0, 8'($urandom_range(255))});
        if (flg[gzhp_pkg::FLG_FEXTRA])
        begin
            // Mostly short extra fields, once in a while one of 256 to 300 bytes.
            xlen = ($urandom_range(39) == 0) ? 16'($urandom_range(256, 300))
                                             : 16'($urandom_range(0, 6));
            byte_plan.push_back({1'b0, xlen[7:0]});
            byte_plan.push_back({1'b0, xlen[15:8]});
            repeat (xlen)
                byte_plan.push_back({1'b0, 8'($urandom_range(255))});
        end
        if (flg[gzhp_pkg::FLG_FNAME])
        begin
            n = $urandom_range(0, 5);
            repeat (n)
                byte_plan.push_back({1'b0, 8'($urandom_range(1, 255))});
            byte_plan.push_back(9'h000);
        end
        if (flg[gzhp_pkg::FLG_FCOMMENT])
        begin
            n = $urandom_range(0, 5);
            repeat (n)
                byte_plan.push_back({1'b0, 8'($urandom_range(1, 255))});
            byte_plan.push_back(9'h000);
        end
        if (flg[gzhp_pkg::FLG_FHCRC])
            repeat (2)
                byte_plan.push_back({1'b0, 8'($urandom_range(255))});
        if ($urandom_range(9) == 0)
        begin
            cut = $urandom_range(1, byte_plan.size() - 1);
            while (byte_plan.size() > cut)
                void'(byte_plan.pop_back());
        end
        n = $urandom_range(0, 4);
        repeat (n)
            byte_plan.push_back({1'b0, 8'($urandom_range(255))});
    endtask

    // Stimulus and verdict.
    initial
    begin
        int          n;
        int          pick;
        logic [7:0]  all_sections;
        all_sections  = 8'((1 << gzhp_pkg::FLG_FHCRC) | (1 << gzhp_pkg::FLG_FEXTRA) |
                           (1 << gzhp_pkg::FLG_FNAME) | (1 << gzhp_pkg::FLG_FCOMMENT));
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Payload byte straight after reset.
        byte_plan.push_back({1'b0, 8'hff});
        // Wrong first magic byte, then a byte after the error.
        byte_plan.push_back({1'b1, 8'h00});
        byte_plan.push_back({1'b0, gzhp_pkg::MAGIC_ID2});
        byte_plan.push_back({1'b0, 8'hff});
        // Wrong second magic byte.
        byte_plan.push_back({1'b1, gzhp_pkg::MAGIC_ID1});
        byte_plan.push_back({1'b0, 8'h00});
        // A header dropped after its magic by a new start.
        byte_plan.push_back({1'b1, gzhp_pkg::MAGIC_ID1});
        byte_plan.push_back({1'b0, gzhp_pkg::MAGIC_ID2});
        // Every optional section, empty extra field, empty strings.
        byte_plan.push_back({1'b1, gzhp_pkg::MAGIC_ID1});
        byte_plan.push_back({1'b0, gzhp_pkg::MAGIC_ID2});
        byte_plan.push_back({1'b0, 8'h08});
        byte_plan.push_back({1'b0, all_sections});
        repeat (4)
            byte_plan.push_back({1'b0, 8'hff});
        byte_plan.push_back({1'b0, 8'h00});
        byte_plan.push_back({1'b0, 8'hff});
        repeat (4)
            byte_plan.push_back(9'h000);
        byte_plan.push_back({1'b0, 8'hff});
        byte_plan.push_back({1'b0, 8'h00});
        // Payload after a complete header.
        byte_plan.push_back({1'b0, 8'h5a});
        play_plan();

        // Random part: mostly real headers, some bad magic and some noise.
        while (items_sent < N_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                plan_member();
            else if (pick < 90)
            begin
                byte_plan.push_back({1'b1, 8'($urandom_range(255))});
                byte_plan.push_back({1'b0, 8'($urandom_range(255))});
                n = $urandom_range(0, 3);
                repeat (n)
                    byte_plan.push_back({1'b0, 8'($urandom_range(255))});
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    byte_plan.push_back({1'($urandom_range(3) == 0), 8'($urandom_range(255))});
            end
            play_plan();
        end
        s_axis_tvalid <= 1'b0;

        // Drain the pending results, then give stray items time to show up.
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/gzhp_pkg.sv
sv/gzip_header_parser.sv
sim/gzip_header_parser_checker.sv
sim/tb.sv
